// File: hdl/fcc_pkg.sv
// fcc_pkg: shared types, constants and helpers of the fan curve controller.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package fcc_pkg;

  localparam int CHANNELS  = 4;
  localparam int IN_FIELDS = 4;
  localparam int CH_USED   = (CHANNELS > IN_FIELDS) ? IN_FIELDS :
                             (CHANNELS < 1) ? 1 : CHANNELS;

  localparam int TEMP_W     = 15;
  localparam int SPEED_W    = 7;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int QUO_W      = 7;
  localparam int DIV_CELLS  = QUO_W;

  localparam int PERCENT_FULL = 100;
  localparam int DUTY_FULL    = 255;
  // speed * 255 / 100 as a multiply by a rounded-up reciprocal
  localparam int DUTY_SHIFT = 19;
  localparam int DUTY_RECIP = (DUTY_FULL * (1 << DUTY_SHIFT) + PERCENT_FULL - 1) / PERCENT_FULL;
  localparam int RECIP_W    = 21;
  localparam int PROD_W     = SPEED_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX = 2'd3;

  localparam logic [1:0] SEL_MIN    = 2'd0;
  localparam logic [1:0] SEL_MAX    = 2'd1;
  localparam logic [1:0] SEL_INTERP = 2'd2;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [SPEED_W-1:0]       speed_t;
  typedef logic [DUTY_W-1:0]        duty_t;

  typedef struct packed {
    temp_t  temp_low;
    temp_t  temp_high;
    speed_t speed_min;
    speed_t speed_max;
  } cfg_t;

  // payload walking down the divider row
  typedef struct packed {
    temp_t              hot;
    logic [1:0]         sel;
    logic               neg;
    logic [TEMP_W-1:0]  dsr;
    logic [TEMP_W-1:0]  rem;
    logic [QUO_W-1:0]   low;
    logic [QUO_W-1:0]   quo;
  } div_word_t;

  function automatic speed_t cap_speed(input logic [SPEED_W-1:0] v);
    cap_speed = (v > SPEED_W'(PERCENT_FULL)) ? SPEED_W'(PERCENT_FULL) : v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/fcc_ifs.sv
// fcc_ifs: valid/ready channel interfaces of the fan curve controller.
// Depends on fcc_pkg for payload types.
`default_nettype none

interface fcc_in_if;
  logic          valid;
  logic          ready;
  fcc_pkg::temp_t temp_a;
  fcc_pkg::temp_t temp_b;
  fcc_pkg::temp_t temp_c;
  fcc_pkg::temp_t temp_d;
  modport source (output valid, temp_a, temp_b, temp_c, temp_d, input ready);
  modport sink   (input valid, temp_a, temp_b, temp_c, temp_d, output ready);
endinterface

interface fcc_out_if;
  logic            valid;
  logic            ready;
  fcc_pkg::temp_t  hottest;
  fcc_pkg::speed_t speed_percent;
  fcc_pkg::duty_t  pwm_duty;
  modport source (output valid, hottest, speed_percent, pwm_duty, input ready);
  modport sink   (input valid, hottest, speed_percent, pwm_duty, output ready);
endinterface

interface fcc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fcc_pkg::CFG_IDX_W-1:0]    index;
  logic [fcc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/fcc_front.sv
// fcc_front: hottest-channel select, threshold classify and numerator multiply.
// Three pipeline stages with valid/ready; depends on fcc_pkg.
`default_nettype none

module fcc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fcc_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire fcc_pkg::temp_t     temps [fcc_pkg::IN_FIELDS],
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      fcc_pkg::div_word_t out_data
);

  logic           v1_r, v2_r, v3_r;
  logic           rdy1, rdy2, rdy3;
  fcc_pkg::temp_t hot1_r, hot1_nxt;
  fcc_pkg::temp_t hot2_r;
  logic [1:0]     sel2_r, sel2_nxt;
  logic signed [fcc_pkg::TEMP_W:0] dt2_r, dt2_nxt, ds2_r, ds2_nxt;
  logic           neg2_r, neg2_nxt;
  logic [fcc_pkg::SPEED_W-1:0] mag2_r, mag2_nxt;
  logic [fcc_pkg::SPEED_W:0]   sd;
  logic [fcc_pkg::TEMP_W+fcc_pkg::SPEED_W-1:0] prod;
  fcc_pkg::div_word_t d3_r, d3_nxt;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    hot1_nxt = temps[0];
    for (int i = 1; i < fcc_pkg::CH_USED; i++) begin
      if (temps[i] > hot1_nxt) begin
        hot1_nxt = temps[i];
      end
    end
  end

  always_comb begin
    if (hot1_r < cfg.temp_low) begin
      sel2_nxt = fcc_pkg::SEL_MIN;
    end else if (hot1_r > cfg.temp_high) begin
      sel2_nxt = fcc_pkg::SEL_MAX;
    end else if (cfg.temp_high == cfg.temp_low) begin
      sel2_nxt = fcc_pkg::SEL_MIN;
    end else begin
      sel2_nxt = fcc_pkg::SEL_INTERP;
    end
    dt2_nxt  = signed'({hot1_r[fcc_pkg::TEMP_W-1], hot1_r})
             - signed'({cfg.temp_low[fcc_pkg::TEMP_W-1], cfg.temp_low});
    ds2_nxt  = signed'({cfg.temp_high[fcc_pkg::TEMP_W-1], cfg.temp_high})
             - signed'({cfg.temp_low[fcc_pkg::TEMP_W-1], cfg.temp_low});
    sd       = {1'b0, cfg.speed_max} - {1'b0, cfg.speed_min};
    neg2_nxt = sd[fcc_pkg::SPEED_W];
    mag2_nxt = neg2_nxt ? fcc_pkg::SPEED_W'(-sd) : sd[fcc_pkg::SPEED_W-1:0];
  end

  // dt is in [0, ds] on the interpolation path, so both fit 15 bits unsigned
  always_comb begin
    prod = (fcc_pkg::TEMP_W+fcc_pkg::SPEED_W)'(dt2_r[fcc_pkg::TEMP_W-1:0])
         * (fcc_pkg::TEMP_W+fcc_pkg::SPEED_W)'(mag2_r);
    d3_nxt.hot = hot2_r;
    d3_nxt.sel = sel2_r;
    d3_nxt.neg = neg2_r;
    d3_nxt.dsr = ds2_r[fcc_pkg::TEMP_W-1:0];
    d3_nxt.rem = prod[fcc_pkg::TEMP_W+fcc_pkg::SPEED_W-1:fcc_pkg::QUO_W];
    d3_nxt.low = prod[fcc_pkg::QUO_W-1:0];
    d3_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      hot1_r <= hot1_nxt;
    end
    if (rdy2 && v1_r) begin
      hot2_r <= hot1_r;
      sel2_r <= sel2_nxt;
      dt2_r  <= dt2_nxt;
      ds2_r  <= ds2_nxt;
      neg2_r <= neg2_nxt;
      mag2_r <= mag2_nxt;
    end
    if (rdy3 && v2_r) begin
      d3_r <= d3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = d3_r;

endmodule

`default_nettype wire

// File: hdl/fcc_div_cell.sv
// fcc_div_cell: one restoring-division cell, one quotient bit per request.
// Instances are chained into a row; depends on fcc_pkg.
`default_nettype none

module fcc_div_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire fcc_pkg::div_word_t in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      fcc_pkg::div_word_t out_data
);

  logic                      v_r;
  fcc_pkg::div_word_t        d_r, d_nxt;
  logic [fcc_pkg::TEMP_W:0]  trial;
  logic                      fit;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    trial = {in_data.rem, in_data.low[fcc_pkg::QUO_W-1]};
    fit   = trial >= {1'b0, in_data.dsr};
    d_nxt = in_data;
    d_nxt.rem = fit ? fcc_pkg::TEMP_W'(trial - {1'b0, in_data.dsr})
                    : trial[fcc_pkg::TEMP_W-1:0];
    d_nxt.low = {in_data.low[fcc_pkg::QUO_W-2:0], 1'b0};
    d_nxt.quo = {in_data.quo[fcc_pkg::QUO_W-2:0], fit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

`default_nettype wire

// File: hdl/fcc_back.sv
// fcc_back: speed select/clamp and PWM duty scaling, two pipeline stages.
// The second stage is the block's output register; depends on fcc_pkg.
`default_nettype none

module fcc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fcc_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire fcc_pkg::div_word_t in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      fcc_pkg::temp_t     hottest,
  output      fcc_pkg::speed_t    speed_percent,
  output      fcc_pkg::duty_t     pwm_duty
);

  logic            v1_r, v2_r, rdy1, rdy2;
  fcc_pkg::temp_t  hot1_r, hot2_r;
  fcc_pkg::speed_t spd1_r, spd1_nxt, spd2_r;
  fcc_pkg::duty_t  duty2_r;
  logic signed [fcc_pkg::SPEED_W+1:0] interp;
  logic [fcc_pkg::PROD_W-1:0]         prod;

  assign rdy2 = !v2_r || out_ready;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    interp = in_data.neg ? signed'({2'b00, cfg.speed_min}) - signed'({2'b00, in_data.quo})
                         : signed'({2'b00, cfg.speed_min}) + signed'({2'b00, in_data.quo});
    case (in_data.sel)
      fcc_pkg::SEL_MIN: spd1_nxt = cfg.speed_min;
      fcc_pkg::SEL_MAX: spd1_nxt = cfg.speed_max;
      default: begin
        if (interp < 0) begin
          spd1_nxt = '0;
        end else if (interp > (fcc_pkg::SPEED_W+2)'(fcc_pkg::PERCENT_FULL)) begin
          spd1_nxt = fcc_pkg::SPEED_W'(fcc_pkg::PERCENT_FULL);
        end else begin
          spd1_nxt = interp[fcc_pkg::SPEED_W-1:0];
        end
      end
    endcase
  end

  assign prod = fcc_pkg::PROD_W'(spd1_r) * fcc_pkg::PROD_W'(fcc_pkg::DUTY_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      hot1_r <= in_data.hot;
      spd1_r <= spd1_nxt;
    end
    if (rdy2 && v1_r) begin
      hot2_r  <= hot1_r;
      spd2_r  <= spd1_r;
      duty2_r <= prod[fcc_pkg::DUTY_SHIFT+fcc_pkg::DUTY_W-1:fcc_pkg::DUTY_SHIFT];
    end
  end

  assign out_valid     = v2_r;
  assign hottest       = hot2_r;
  assign speed_percent = spd2_r;
  assign pwm_duty      = duty2_r;

endmodule

`default_nettype wire

// File: hdl/fan_curve_controller.sv
// fan_curve_controller: top level of the threshold fan speed curve.
// Depends on fcc_pkg, fcc_ifs, fcc_front, fcc_div_cell and fcc_back.
//
// Usage:
//   in_ch  : one request carries four channel temperatures (0.01 degC, signed,
//            0 for an invalid channel).
//   out_ch : one request per input request, in order: hottest temperature,
//            fan speed percent and 8-bit PWM duty.
//   cfg_ch : register writes (0 temp_low, 1 temp_high, 2 speed_min,
//            3 speed_max); always ready, write only while no request is in flight.
//   A request passes three front stages, a row of seven divider cells
//   (one quotient bit each) and two back stages. Throughput is one request
//   per cycle while out_ch does not stall.
//   Every stage holds its request while the next one is full, so a stalled
//   out_ch fills the pipe and in_ch.ready drops once all 12 stages are full.
//   Synchronous reset empties the pipe and loads 30.00/50.00 degC, 30 % and
//   100 % into the registers.
`default_nettype none

module fan_curve_controller (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fcc_in_if.sink     in_ch,
  fcc_out_if.source  out_ch,
  fcc_cfg_if.sink    cfg_ch
);

  fcc_pkg::cfg_t      cfg_r;
  fcc_pkg::temp_t     temps [fcc_pkg::IN_FIELDS];
  logic               cv   [fcc_pkg::DIV_CELLS+1];
  logic               cr   [fcc_pkg::DIV_CELLS+1];
  fcc_pkg::div_word_t cd   [fcc_pkg::DIV_CELLS+1];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_low  <= fcc_pkg::TEMP_W'(3000);
      cfg_r.temp_high <= fcc_pkg::TEMP_W'(5000);
      cfg_r.speed_min <= fcc_pkg::SPEED_W'(30);
      cfg_r.speed_max <= fcc_pkg::SPEED_W'(100);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        fcc_pkg::REG_TEMP_LOW:  cfg_r.temp_low  <= cfg_ch.data;
        fcc_pkg::REG_TEMP_HIGH: cfg_r.temp_high <= cfg_ch.data;
        fcc_pkg::REG_SPEED_MIN:
          cfg_r.speed_min <= fcc_pkg::cap_speed(cfg_ch.data[fcc_pkg::SPEED_W-1:0]);
        fcc_pkg::REG_SPEED_MAX:
          cfg_r.speed_max <= fcc_pkg::cap_speed(cfg_ch.data[fcc_pkg::SPEED_W-1:0]);
        default: ;
      endcase
    end
  end

  assign temps[0] = in_ch.temp_a;
  assign temps[1] = in_ch.temp_b;
  assign temps[2] = in_ch.temp_c;
  assign temps[3] = in_ch.temp_d;

  fcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .temps     (temps),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_data  (cd[0])
  );

  for (genvar g = 0; g < fcc_pkg::DIV_CELLS; g++) begin : g_cell
    fcc_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[g]),
      .in_ready  (cr[g]),
      .in_data   (cd[g]),
      .out_valid (cv[g+1]),
      .out_ready (cr[g+1]),
      .out_data  (cd[g+1])
    );
  end

  fcc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (cv[fcc_pkg::DIV_CELLS]),
    .in_ready      (cr[fcc_pkg::DIV_CELLS]),
    .in_data       (cd[fcc_pkg::DIV_CELLS]),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .hottest       (out_ch.hottest),
    .speed_percent (out_ch.speed_percent),
    .pwm_duty      (out_ch.pwm_duty)
  );

endmodule

`default_nettype wire

// File: hdl/fcc_checker.sv
// fcc_checker: port-level assertions for the fan curve controller.
// Bound to fan_curve_controller; depends on fcc_pkg.
`default_nettype none

module fcc_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire fcc_pkg::speed_t speed_percent,
  input wire fcc_pkg::duty_t  pwm_duty
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled request dropped");

  a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> speed_percent <= fcc_pkg::SPEED_W'(fcc_pkg::PERCENT_FULL))
    else $error("speed above full scale");

  a_duty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((speed_percent == fcc_pkg::SPEED_W'(fcc_pkg::PERCENT_FULL))
                   == (pwm_duty == fcc_pkg::DUTY_W'(fcc_pkg::DUTY_FULL))))
    else $error("duty inconsistent with speed at full scale");

endmodule

bind fan_curve_controller fcc_checker u_fcc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .speed_percent (out_ch.speed_percent),
  .pwm_duty      (out_ch.pwm_duty)
);

`default_nettype wire
